>>> hdl/adseg_pkg.sv
// ----------------------------------------------------------------------------
// adseg_pkg: shared types and constants for the ascent/descent segmenter
// Widths of the sample, position and tolerance fields, the CSR map and the
// result record that is queued toward the result channel.
// ----------------------------------------------------------------------------
package adseg_pkg;

   // field widths
   localparam int HEIGHT_BITS = 18;
   localparam int POS_BITS    = 16;
   localparam int END_BITS    = POS_BITS + 1;
   localparam int TOL_BITS    = 17;
   localparam int DIFF_BITS   = HEIGHT_BITS + 2;

   // last usable point index; the position counter stops here
   localparam logic [POS_BITS-1:0] POS_MAX = {POS_BITS{1'b1}};

   // CSR map: one register per 32-bit word
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam logic CSR_IDX_CHANGE_TOLERANCE = 1'b0;
   localparam logic [TOL_BITS-1:0] TOL_RESET = 17'd100;

   // result queue
   localparam int FIFO_DEPTH    = 8;
   localparam int FIFO_IDX_BITS = 3;
   localparam int FIFO_CNT_BITS = 4;

   // direction codes
   localparam logic DIR_FALLING = 1'b0;
   localparam logic DIR_RISING  = 1'b1;

   typedef struct packed {
      logic [POS_BITS-1:0] segment_start;
      logic [END_BITS-1:0] segment_end;
      logic                direction;
      logic                final_section;
      logic                last_of_run;
   } result_type;

endpackage

>>> hdl/adseg_req_if.sv
// ----------------------------------------------------------------------------
// adseg_req_if: sample channel
// Valid/ready channel carrying one height sample and its end-of-track flag.
// ----------------------------------------------------------------------------
interface adseg_req_if;
   logic                                    valid;
   logic                                    ready;
   logic signed [adseg_pkg::HEIGHT_BITS-1:0] height_sample;
   logic                                    end_of_track;

   modport source (output valid, height_sample, end_of_track, input ready);
   modport sink   (input valid, height_sample, end_of_track, output ready);
endinterface

>>> hdl/adseg_rsp_if.sv
// ----------------------------------------------------------------------------
// adseg_rsp_if: section channel
// Valid/ready channel carrying one detected section per transfer.
// ----------------------------------------------------------------------------
interface adseg_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [adseg_pkg::POS_BITS-1:0]    segment_start;
   logic [adseg_pkg::END_BITS-1:0]    segment_end;
   logic                              direction;
   logic                              final_section;
   logic                              last_of_run;

   modport source (output valid, segment_start, segment_end, direction,
                   final_section, last_of_run, input ready);
   modport sink   (input valid, segment_start, segment_end, direction,
                   final_section, last_of_run, output ready);
endinterface

>>> hdl/ascent_descent_segmenter.sv
// ----------------------------------------------------------------------------
// ascent_descent_segmenter: hysteresis peak/valley section detector
// Tracks min/max of the current section and closes a rising or falling
// section once the height reverses by more than change_tolerance.
// ----------------------------------------------------------------------------
//
//   channel   | direction | transfers
//   ----------+-----------+-------------------------------------------------
//   req_ch    | in        | height_sample, end_of_track
//   rsp_ch    | out       | segment_start, segment_end, direction,
//             |           | final_section, last_of_run (0..2 per sample)
//   csr (APB) | in/out    | change_tolerance at byte address 0
//
// One sample per cycle while req_ch.ready is high. A sample is held in the
// input register, is evaluated against the tracker state and its sections
// land in an 8-entry result queue whose head is presented on rsp_ch.
// The rate is set by the result queue drain: one section leaves per cycle
// while rsp_ch.ready is high, so tracks whose samples close two sections in
// a row slow to that drain. req_ch.ready drops when the queue cannot take
// two more sections for each sample in flight. Synchronous reset empties the
// queue and restarts tracking; change_tolerance returns to 100.
//
module ascent_descent_segmenter (
   input  logic                                clock,
   input  logic                                reset,
   adseg_req_if.sink                           req_ch,
   adseg_rsp_if.source                         rsp_ch,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [adseg_pkg::CSR_ADDR_BITS-1:0] paddr,
   input  logic [adseg_pkg::CSR_DATA_BITS-1:0] pwdata,
   output logic [adseg_pkg::CSR_DATA_BITS-1:0] prdata,
   output logic                                pready
);

   localparam int HB = adseg_pkg::HEIGHT_BITS;
   localparam int PB = adseg_pkg::POS_BITS;
   localparam int DB = adseg_pkg::DIFF_BITS;
   localparam int TB = adseg_pkg::TOL_BITS;
   localparam int CB = adseg_pkg::FIFO_CNT_BITS;
   localparam int IB = adseg_pkg::FIFO_IDX_BITS;

   // ---------------------------------------------------------------------
   // CSR port
   // ---------------------------------------------------------------------
   logic [TB-1:0] tol_ff, tol_in;
   logic          csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      tol_in = tol_ff;
      if (csr_write && (paddr[2] == adseg_pkg::CSR_IDX_CHANGE_TOLERANCE)) begin
         tol_in = pwdata[TB-1:0];
      end
   end

   always_comb begin
      prdata = '0;
      if (paddr[2] == adseg_pkg::CSR_IDX_CHANGE_TOLERANCE) begin
         prdata = {{(adseg_pkg::CSR_DATA_BITS-TB){1'b0}}, tol_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= adseg_pkg::TOL_RESET;
      end else begin
         tol_ff <= tol_in;
      end
   end

   // ---------------------------------------------------------------------
   // Input register
   // ---------------------------------------------------------------------
   logic                 s1_valid_ff;
   logic signed [HB-1:0] s1_height_ff;
   logic                 s1_last_ff;
   logic                 req_xfer;
   logic [CB:0]          credit_need;
   logic [CB-1:0]        count_ff, count_in;

   // room for two sections from the sample in flight plus two from a new one
   assign credit_need  = {1'b0, count_ff} + (s1_valid_ff ? (CB+1)'(2) : '0);
   assign req_ch.ready = (credit_need <= (CB+1)'(adseg_pkg::FIFO_DEPTH - 2));
   assign req_xfer     = req_ch.valid && req_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_xfer;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_height_ff <= req_ch.height_sample;
         s1_last_ff   <= req_ch.end_of_track;
      end
   end

   // ---------------------------------------------------------------------
   // Tracker state
   // ---------------------------------------------------------------------
   logic                 started_ff, started_in;
   logic [PB-1:0]        pos_ff, pos_in;
   logic [PB-1:0]        begin_ff, begin_in;
   logic [PB-1:0]        low_pos_ff, low_pos_in;
   logic [PB-1:0]        high_pos_ff, high_pos_in;
   logic signed [HB-1:0] low_h_ff, low_h_in;
   logic signed [HB-1:0] high_h_ff, high_h_in;
   logic signed [HB-1:0] sec_h_ff, sec_h_in;

   logic signed [DB-1:0] drop, climb, tol_s, up_span, down_span;
   logic                 close_vld, close_dir;
   logic [PB-1:0]        close_pos;
   adseg_pkg::result_type res_a, res_b;
   logic [1:0]           push_cnt;

   assign tol_s = $signed({{(DB-TB){1'b0}}, tol_ff});
   assign drop  = DB'(high_h_ff) - DB'(s1_height_ff);
   assign climb = DB'(s1_height_ff) - DB'(low_h_ff);

   // per-sample update: extremes, reversal check, section close
   always_comb begin
      started_in  = started_ff;
      pos_in      = pos_ff;
      begin_in    = begin_ff;
      low_pos_in  = low_pos_ff;
      high_pos_in = high_pos_ff;
      low_h_in    = low_h_ff;
      high_h_in   = high_h_ff;
      sec_h_in    = sec_h_ff;
      close_vld   = 1'b0;
      close_dir   = adseg_pkg::DIR_FALLING;
      close_pos   = low_pos_ff;
      if (s1_valid_ff) begin
         if (!started_ff) begin
            started_in  = 1'b1;
            pos_in      = '0;
            begin_in    = '0;
            low_pos_in  = '0;
            high_pos_in = '0;
            low_h_in    = s1_height_ff;
            high_h_in   = s1_height_ff;
            sec_h_in    = s1_height_ff;
         end else begin
            if (pos_ff != adseg_pkg::POS_MAX) begin
               pos_in = pos_ff + PB'(1);
            end
            if (s1_height_ff < low_h_ff) begin
               low_h_in   = s1_height_ff;
               low_pos_in = pos_in;
            end else if (s1_height_ff > high_h_ff) begin
               high_h_in   = s1_height_ff;
               high_pos_in = pos_in;
            end else if (low_pos_ff < high_pos_ff) begin
               // max is newer: look for a drop
               if (drop > tol_s) begin
                  close_vld  = 1'b1;
                  close_dir  = adseg_pkg::DIR_RISING;
                  close_pos  = high_pos_ff;
                  begin_in   = high_pos_ff;
                  sec_h_in   = high_h_ff;
                  low_pos_in = pos_in;
                  low_h_in   = s1_height_ff;
               end
            end else begin
               // min is newer (or tied): look for a climb
               if (climb > tol_s) begin
                  close_vld   = 1'b1;
                  close_dir   = adseg_pkg::DIR_FALLING;
                  close_pos   = low_pos_ff;
                  begin_in    = low_pos_ff;
                  sec_h_in    = low_h_ff;
                  high_pos_in = pos_in;
                  high_h_in   = s1_height_ff;
               end
            end
         end
         if (s1_last_ff) begin
            started_in = 1'b0;
         end
      end
   end

   // final section direction from the updated extremes
   assign up_span   = DB'(high_h_in) - DB'(sec_h_in);
   assign down_span = DB'(sec_h_in) - DB'(low_h_in);

   // result records for this sample
   always_comb begin
      adseg_pkg::result_type r_close, r_final;
      r_close.segment_start = begin_ff;
      r_close.segment_end   = {1'b0, close_pos} + adseg_pkg::END_BITS'(1);
      r_close.direction     = close_dir;
      r_close.final_section = 1'b0;
      r_close.last_of_run   = !s1_last_ff;
      r_final.segment_start = begin_in;
      r_final.segment_end   = {1'b0, pos_in} + adseg_pkg::END_BITS'(1);
      r_final.direction     = (up_span > down_span) ? adseg_pkg::DIR_RISING
                                                    : adseg_pkg::DIR_FALLING;
      r_final.final_section = 1'b1;
      r_final.last_of_run   = 1'b1;
      res_a    = close_vld ? r_close : r_final;
      res_b    = r_final;
      push_cnt = '0;
      if (s1_valid_ff) begin
         push_cnt = 2'(close_vld) + 2'(s1_last_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         started_ff <= 1'b0;
      end else begin
         started_ff <= started_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      begin_ff    <= begin_in;
      low_pos_ff  <= low_pos_in;
      high_pos_ff <= high_pos_in;
      low_h_ff    <= low_h_in;
      high_h_ff   <= high_h_in;
      sec_h_ff    <= sec_h_in;
   end

   // ---------------------------------------------------------------------
   // Result queue
   // ---------------------------------------------------------------------
   adseg_pkg::result_type fifo_ff [adseg_pkg::FIFO_DEPTH];
   logic [IB-1:0] head_ff, head_in, tail_ff, tail_in;
   logic [IB-1:0] tail_nxt;
   logic          pop;
   adseg_pkg::result_type head_res;

   assign pop      = rsp_ch.valid && rsp_ch.ready;
   assign tail_nxt = tail_ff + IB'(1);
   assign head_in  = pop ? head_ff + IB'(1) : head_ff;
   assign tail_in  = tail_ff + IB'(push_cnt);
   assign count_in = count_ff + CB'(push_cnt) - CB'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_cnt != 2'd0) begin
         fifo_ff[tail_ff] <= res_a;
      end
      if (push_cnt == 2'd2) begin
         fifo_ff[tail_nxt] <= res_b;
      end
   end

   assign head_res             = fifo_ff[head_ff];
   assign rsp_ch.valid         = (count_ff != '0);
   assign rsp_ch.segment_start = head_res.segment_start;
   assign rsp_ch.segment_end   = head_res.segment_end;
   assign rsp_ch.direction     = head_res.direction;
   assign rsp_ch.final_section = head_res.final_section;
   assign rsp_ch.last_of_run   = head_res.last_of_run;

   // ---------------------------------------------------------------------
   // Checks
   // ---------------------------------------------------------------------
`ifndef SYNTHESIS
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CB'(adseg_pkg::FIFO_DEPTH))
      else $error("result queue over depth");

   a_push_fits: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, count_ff} + (CB+1)'(push_cnt)) <=
      ((CB+1)'(adseg_pkg::FIFO_DEPTH) + (CB+1)'(pop)))
      else $error("section pushed into full queue");

   a_track_end_clears: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && s1_last_ff |=> !started_ff)
      else $error("tracker still running after end of track");

   a_final_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.final_section |-> rsp_ch.last_of_run)
      else $error("final section not last of its run");

   a_pos_no_wrap: assert property (@(posedge clock) disable iff (reset)
      started_ff && $past(started_ff) |-> pos_ff >= $past(pos_ff))
      else $error("point index wrapped");
`endif

endmodule

>>> verif/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the ascent/descent segmenter
// Drives height samples over the sample channel and programs change_tolerance
// over the APB port. A software tracker predicts all sections of each
// accepted sample, and every section transfer is checked field by field in
// order. A short table of directed samples comes first. Random tracks follow
// under several tolerance settings and sender/receiver idle mixes.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int CLOCK_HALF    = 10;
   localparam int RESET_CYCLES  = 10;
   localparam int SETTLE_CYCLES = 8;
   localparam int LONG_STALL    = 400;
   localparam int PHASE_ITEMS   = 250;
   localparam int PHASES        = 6;
   localparam int CYCLE_LIMIT   = 1000000;
   localparam int HEIGHT_HI     = 131071;
   localparam int HEIGHT_LO     = -131072;

   typedef logic signed [adseg_pkg::HEIGHT_BITS-1:0] height_type;

   // one row of the directed table; listed is set where the single
   // resulting section is written out by hand
   typedef struct packed {
      height_type            height;
      logic                  end_mark;
      logic [16:0]           repeats;
      logic                  listed;
      adseg_pkg::result_type section;
   } stim_row_type;

   localparam int DIRECTED_ROWS = 26;

   logic clock;
   logic reset;

   logic                                csr_psel;
   logic                                csr_penable;
   logic                                csr_pwrite;
   logic [adseg_pkg::CSR_ADDR_BITS-1:0] csr_paddr;
   logic [adseg_pkg::CSR_DATA_BITS-1:0] csr_pwdata;
   logic [adseg_pkg::CSR_DATA_BITS-1:0] csr_prdata;
   logic                                csr_pready;

   adseg_req_if req_if ();
   adseg_rsp_if rsp_if ();

   ascent_descent_segmenter dut (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_if),
      .rsp_ch  (rsp_if),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready)
   );

   // tracker model state
   logic                           trk_started;
   logic [adseg_pkg::POS_BITS-1:0] trk_position;
   logic [adseg_pkg::POS_BITS-1:0] trk_section_begin;
   logic [adseg_pkg::POS_BITS-1:0] trk_low_pos;
   logic [adseg_pkg::POS_BITS-1:0] trk_high_pos;
   height_type                     trk_low;
   height_type                     trk_high;
   height_type                     trk_section_height;
   logic [adseg_pkg::TOL_BITS-1:0] tolerance;

   adseg_pkg::result_type fresh_secs [2];
   int                    fresh_count;
   adseg_pkg::result_type pending_sections [$];

   int mismatches   = 0;
   int cycle_count  = 0;
   int tx_idle_pct  = 0;
   int rx_idle_pct  = 0;
   int stall_asks   = 0;
   int stall_served = 0;
   int stall_left   = 0;

   // directed samples, tolerance at its reset value of 100
   stim_row_type directed_rows [DIRECTED_ROWS] = '{
      // single-point tracks: section [0,1), falling on the tie
      '{18'sd0,      1'b1, 17'd1, 1'b1, '{16'd0, 17'd1, adseg_pkg::DIR_FALLING, 1'b1, 1'b1}},
      '{18'sh1FFFF,  1'b1, 17'd1, 1'b1, '{16'd0, 17'd1, adseg_pkg::DIR_FALLING, 1'b1, 1'b1}},
      // fall of exactly the tolerance holds, one more closes a rising section
      '{18'sd0,      1'b0, 17'd1, 1'b0, '0},
      '{18'sd200,    1'b0, 17'd1, 1'b0, '0},
      '{18'sd100,    1'b0, 17'd1, 1'b0, '0},
      '{18'sd99,     1'b0, 17'd1, 1'b0, '0},
      '{18'sd99,     1'b0, 17'd1, 1'b0, '0},
      '{18'sd200,    1'b0, 17'd1, 1'b0, '0},
      '{18'sd50,     1'b1, 17'd1, 1'b0, '0},
      // closing and final section from the same sample
      '{18'sd0,      1'b0, 17'd1, 1'b0, '0},
      '{18'sd300,    1'b0, 17'd1, 1'b0, '0},
      '{18'sd0,      1'b1, 17'd1, 1'b0, '0},
      // equal rise and fall at the end: falling
      '{18'sd0,      1'b0, 17'd1, 1'b0, '0},
      '{18'sd50,     1'b0, 17'd1, 1'b0, '0},
      '{-18'sd50,    1'b1, 17'd1, 1'b0, '0},
      // height extremes (18'sh20000 is the most negative sample)
      '{18'sh1FFFF,  1'b0, 17'd1, 1'b0, '0},
      '{18'sh20000,  1'b0, 17'd1, 1'b0, '0},
      '{18'sd0,      1'b0, 17'd1, 1'b0, '0},
      '{18'sh1FFFF,  1'b1, 17'd1, 1'b0, '0},
      // flat run, then a swing each way; a rise of one over the tolerance
      // closes a falling section
      '{18'sd0,      1'b0, 17'd1, 1'b0, '0},
      '{18'sd10,     1'b0, 17'd40, 1'b0, '0},
      '{18'sd500,    1'b0, 17'd1, 1'b0, '0},
      '{-18'sd500,   1'b0, 17'd1, 1'b0, '0},
      '{-18'sd450,   1'b0, 17'd1, 1'b0, '0},
      '{-18'sd399,   1'b0, 17'd1, 1'b0, '0},
      '{18'sd0,      1'b1, 17'd1, 1'b0, '0}
   };

   // clock
   initial begin
      clock = 1'b0;
      forever #CLOCK_HALF clock = ~clock;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // tracker model
   // ------------------------------------------------------------------------
   function automatic void clear_tracker();
      trk_started        = 1'b0;
      trk_position       = '0;
      trk_section_begin  = '0;
      trk_low_pos        = '0;
      trk_high_pos       = '0;
      trk_low            = '0;
      trk_high           = '0;
      trk_section_height = '0;
   endfunction

   function automatic void add_section(input logic [adseg_pkg::POS_BITS-1:0] first,
                                       input logic [adseg_pkg::END_BITS-1:0] past_end,
                                       input logic dir, input logic fin);
      fresh_secs[fresh_count] = '{first, past_end, dir, fin, 1'b0};
      fresh_count++;
   endfunction

   // advance the tracker by one sample; sections land in fresh_secs
   function automatic void track_sample(input height_type h, input logic eot);
      int rise;
      int fall;
      fresh_count = 0;
      if (!trk_started) begin
         trk_started        = 1'b1;
         trk_position       = '0;
         trk_section_begin  = '0;
         trk_low_pos        = '0;
         trk_high_pos       = '0;
         trk_low            = h;
         trk_high           = h;
         trk_section_height = h;
      end else begin
         if (trk_position != adseg_pkg::POS_MAX)
            trk_position++;
         if (h < trk_low) begin
            trk_low     = h;
            trk_low_pos = trk_position;
         end else if (h > trk_high) begin
            trk_high     = h;
            trk_high_pos = trk_position;
         end else if (trk_low_pos < trk_high_pos) begin
            // maximum is newer: look for a fall
            if (int'(trk_high) - int'(h) > int'(tolerance)) begin
               add_section(trk_section_begin,
                           adseg_pkg::END_BITS'(trk_high_pos) + 1'b1,
                           adseg_pkg::DIR_RISING, 1'b0);
               trk_section_begin  = trk_high_pos;
               trk_section_height = trk_high;
               trk_low_pos        = trk_position;
               trk_low            = h;
            end
         end else begin
            // minimum is newer (or same point): look for a rise
            if (int'(h) - int'(trk_low) > int'(tolerance)) begin
               add_section(trk_section_begin,
                           adseg_pkg::END_BITS'(trk_low_pos) + 1'b1,
                           adseg_pkg::DIR_FALLING, 1'b0);
               trk_section_begin  = trk_low_pos;
               trk_section_height = trk_low;
               trk_high_pos       = trk_position;
               trk_high           = h;
            end
         end
      end
      if (eot) begin
         rise = int'(trk_high) - int'(trk_section_height);
         fall = int'(trk_section_height) - int'(trk_low);
         add_section(trk_section_begin, adseg_pkg::END_BITS'(trk_position) + 1'b1,
                     (rise > fall) ? adseg_pkg::DIR_RISING : adseg_pkg::DIR_FALLING,
                     1'b1);
         clear_tracker();
      end
      if (fresh_count > 0)
         fresh_secs[fresh_count-1].last_of_run = 1'b1;
   endfunction

   // ------------------------------------------------------------------------
   // section checker
   // ------------------------------------------------------------------------
   function automatic void check_field(input string label,
                                       input logic [adseg_pkg::END_BITS-1:0] want,
                                       input logic [adseg_pkg::END_BITS-1:0] got);
      if (got !== want) begin
         $display("%0t ns: %s expected %0d, got %0d", $time, label, want, got);
         mismatches++;
      end
   endfunction

   always @(posedge clock) begin
      adseg_pkg::result_type want;
      if (!reset && rsp_if.valid === 1'b1 && rsp_if.ready === 1'b1) begin
         if (pending_sections.size() == 0) begin
            $display("%0t ns: section transfer with none expected, got [%0d,%0d)",
                     $time, rsp_if.segment_start, rsp_if.segment_end);
            mismatches++;
         end else begin
            want = pending_sections.pop_front();
            check_field("segment_start", adseg_pkg::END_BITS'(want.segment_start),
                        adseg_pkg::END_BITS'(rsp_if.segment_start));
            check_field("segment_end", want.segment_end, rsp_if.segment_end);
            check_field("direction", adseg_pkg::END_BITS'(want.direction),
                        adseg_pkg::END_BITS'(rsp_if.direction));
            check_field("final_section", adseg_pkg::END_BITS'(want.final_section),
                        adseg_pkg::END_BITS'(rsp_if.final_section));
            check_field("last_of_run", adseg_pkg::END_BITS'(want.last_of_run),
                        adseg_pkg::END_BITS'(rsp_if.last_of_run));
         end
      end
   end

   // section receiver: random back-pressure plus a single long hold-off
   always @(negedge clock) begin
      if (stall_asks != stall_served) begin
         stall_left   = LONG_STALL;
         stall_served = stall_asks;
      end
      if (stall_left > 0) begin
         rsp_if.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_if.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
      end
   end

   // ------------------------------------------------------------------------
   // drivers; every task is entered and left at a falling edge
   // ------------------------------------------------------------------------
   task automatic send_sample(input height_type h, input logic eot,
                              input logic listed,
                              input adseg_pkg::result_type listed_sec);
      while ($urandom_range(0, 99) < tx_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid         <= 1'b1;
      req_if.height_sample <= h;
      req_if.end_of_track  <= eot;
      do @(posedge clock); while (req_if.ready !== 1'b1);
      track_sample(h, eot);
      if (listed)
         pending_sections.insert(pending_sections.size(), listed_sec);
      else
         for (int i = 0; i < fresh_count; i++)
            pending_sections.insert(pending_sections.size(), fresh_secs[i]);
      @(negedge clock);
   endtask

   task automatic csr_transfer(input logic wr,
                               input logic [adseg_pkg::CSR_DATA_BITS-1:0] wdata,
                               output logic [adseg_pkg::CSR_DATA_BITS-1:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= wr;
      csr_paddr   <= {adseg_pkg::CSR_IDX_CHANGE_TOLERANCE, 2'b00};
      csr_pwdata  <= wdata;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (csr_pready !== 1'b1);
      rdata = csr_prdata;
      if (wr)
         tolerance = wdata[adseg_pkg::TOL_BITS-1:0];
      @(negedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic check_tolerance_reg(input logic [adseg_pkg::TOL_BITS-1:0] want);
      logic [adseg_pkg::CSR_DATA_BITS-1:0] rdata;
      csr_transfer(1'b0, '0, rdata);
      if (rdata !== adseg_pkg::CSR_DATA_BITS'(want)) begin
         $display("%0t ns: change_tolerance read expected %0d, got %0d",
                  $time, want, rdata);
         mismatches++;
      end
   endtask

   task automatic write_tolerance(input logic [adseg_pkg::TOL_BITS-1:0] value);
      logic [adseg_pkg::CSR_DATA_BITS-1:0] rdata;
      csr_transfer(1'b1, adseg_pkg::CSR_DATA_BITS'(value), rdata);
      check_tolerance_reg(value);
   endtask

   // hold the sender until every section is out and the pipe is empty
   task automatic drain_sections();
      while (pending_sections.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // random tracks: mostly a random walk scaled to the tolerance so that
   // sections close, with full-range spikes mixed in
   task automatic run_random_tracks(input int item_goal);
      int         sent;
      int         len;
      int         span;
      int         level;
      height_type h;
      sent = 0;
      while (sent < item_goal) begin
         len   = ($urandom_range(0, 19) == 0) ? 1 : $urandom_range(2, 40);
         span  = (tolerance > 65535) ? HEIGHT_HI : 2 * int'(tolerance) + 4;
         level = int'($urandom_range(0, 262143)) + HEIGHT_LO;
         for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 9) == 0) begin
               h = height_type'($urandom);
            end else begin
               level = level + int'($urandom_range(0, 2 * span)) - span;
               if (level > HEIGHT_HI) level = HEIGHT_HI;
               if (level < HEIGHT_LO) level = HEIGHT_LO;
               h = height_type'(level);
            end
            send_sample(h, k == len - 1, 1'b0, '0);
            sent++;
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------------
   initial begin
      logic [adseg_pkg::TOL_BITS-1:0] phase_tol [PHASES];
      reset                = 1'b1;
      req_if.valid         = 1'b0;
      req_if.height_sample = '0;
      req_if.end_of_track  = 1'b0;
      csr_psel             = 1'b0;
      csr_penable          = 1'b0;
      csr_pwrite           = 1'b0;
      csr_paddr            = '0;
      csr_pwdata           = '0;
      tolerance            = adseg_pkg::TOL_RESET;
      clear_tracker();

      phase_tol[0] = '0;
      phase_tol[1] = {adseg_pkg::TOL_BITS{1'b1}};
      phase_tol[2] = adseg_pkg::TOL_BITS'($urandom_range(1, 400));
      phase_tol[3] = adseg_pkg::TOL_BITS'(100000);
      phase_tol[4] = adseg_pkg::TOL_BITS'($urandom_range(20, 2000));
      phase_tol[5] = adseg_pkg::TOL_BITS'(1);

      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // sender sparse, receiver slow
      tx_idle_pct = 31;
      rx_idle_pct = 74;
      check_tolerance_reg(adseg_pkg::TOL_RESET);

      // directed table
      foreach (directed_rows[r])
         for (int n = 0; n < int'(directed_rows[r].repeats); n++)
            send_sample(directed_rows[r].height, directed_rows[r].end_mark,
                        directed_rows[r].listed && n == 0, directed_rows[r].section);
      req_if.valid <= 1'b0;
      drain_sections();

      // random phases, each under its own tolerance
      for (int p = 0; p < PHASES; p++) begin
         if (p == 2) begin
            tx_idle_pct = 74;
            rx_idle_pct = 31;
         end else if (p == 4) begin
            tx_idle_pct = 0;
            rx_idle_pct = 0;
         end
         write_tolerance(phase_tol[p]);
         // long receiver hold-off while samples keep coming
         if (p == 0)
            stall_asks++;
         run_random_tracks(PHASE_ITEMS);
         req_if.valid <= 1'b0;
         drain_sections();
      end

      if (mismatches == 0)
         $display("SCOREBOARD CLEAN");
      else
         $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

>>> sim.f
hdl/adseg_pkg.sv
hdl/adseg_req_if.sv
hdl/adseg_rsp_if.sv
hdl/ascent_descent_segmenter.sv
verif/tb_top.sv
